// File: rtl/cdjc_pkg.sv
// ---------------------------------------------------------------------------
// cdjc_pkg: shared constants and tables for the calendar converter
// Operation codes, time constants, reciprocal factors for the constant
// divisions and the Gregorian month tables.
// ---------------------------------------------------------------------------
package cdjc_pkg;

	typedef enum logic {
		OP_DATE = 1'b0,
		OP_DOY  = 1'b1
	} op_t;

	localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
	localparam logic [26:0] MS_MAX_TOD  = 27'd86399999;
	localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
	localparam logic [15:0] MS_PER_MIN  = 16'd60000;
	localparam logic [22:0] JD_OFFSET   = 23'd1720981;

	// x divisible by 25 exactly when x times the inverse of 25 modulo 2^14 is
	// no more than (2^14 - 1) / 25.
	localparam logic [13:0] INV25     = 14'd7209;
	localparam logic [13:0] DIV25_MAX = 14'd655;

	// Fraction is floor(ms * 2^22 / 84375); FRAC_RECIP is floor(2^48 / 84375).
	localparam logic [31:0] FRAC_RECIP = 32'd3335999723;
	localparam logic [16:0] FRAC_DIV   = 17'd84375;

	// floor(2^32 / 60000) and ceil(2^17 / 60).
	localparam logic [16:0] MIN_RECIP  = 17'd71582;
	localparam logic [11:0] HOUR_RECIP = 12'd2185;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// floor(30.6001 * (m + 1)) with January and February counted as months 13 and 14.
	function automatic logic [8:0] month_term(input logic [3:0] month);
		logic [8:0] t;
		unique case (month)
			4'd1:    t = 9'd428;
			4'd2:    t = 9'd459;
			4'd3:    t = 9'd122;
			4'd4:    t = 9'd153;
			4'd5:    t = 9'd183;
			4'd6:    t = 9'd214;
			4'd7:    t = 9'd244;
			4'd8:    t = 9'd275;
			4'd9:    t = 9'd306;
			4'd10:   t = 9'd336;
			4'd11:   t = 9'd367;
			default: t = 9'd397;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/cdjc_frac_div.sv
// ---------------------------------------------------------------------------
// cdjc_frac_div: day fraction divider
// Three-stage pipeline giving floor(ms * 2^32 / 86400000) as Q0.32, by a
// reciprocal multiply, a remainder check and a correction of up to two; a full day gives all ones.
// ---------------------------------------------------------------------------
module cdjc_frac_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [26:0] msd,
	output logic        out_valid,
	output logic [31:0] frac
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        full_s1, full_s2;
	logic [31:0] q_est_s1, q_est_s2;
	logic [17:0] rem_s2;
	logic [31:0] frac_s3;

	logic [58:0] prod;
	logic [17:0] low_prod;
	logic [31:0] q_fix;

	assign prod = 59'(msd) * 59'(cdjc_pkg::FRAC_RECIP);

	// The true remainder stays below three divisors, so 18 low bits suffice and
	// the shifted dividend contributes nothing to them.
	assign low_prod = 18'(q_est_s1[17:0] * 18'(cdjc_pkg::FRAC_DIV));

	always_comb begin
		if (rem_s2 >= 18'(2 * cdjc_pkg::FRAC_DIV)) begin
			q_fix = q_est_s2 + 32'd2;
		end else if (rem_s2 >= 18'(cdjc_pkg::FRAC_DIV)) begin
			q_fix = q_est_s2 + 32'd1;
		end else begin
			q_fix = q_est_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		full_s1  <= (msd == cdjc_pkg::MS_PER_DAY);
		q_est_s1 <= prod[57:26];
		full_s2  <= full_s1;
		q_est_s2 <= q_est_s1;
		rem_s2   <= 18'd0 - low_prod;
		frac_s3  <= full_s2 ? 32'hFFFF_FFFF : q_fix;
	end

	assign out_valid = valid_s3;
	assign frac      = frac_s3;

endmodule

// File: rtl/calendar_date_julian_converter.sv
// ---------------------------------------------------------------------------
// calendar_date_julian_converter: Gregorian date and Julian date converter
// Converts a calendar date and time, or a day of year and time of day, into
// the other form plus the Julian date, one item per clock.
// ---------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. busy
// is tied low: the six-stage pipeline accepts a new item in every cycle, so
// the throughput is one item per clock.
// Each result is shown for one cycle with done high, once its item has passed
// through every stage; results leave in the order items came in.
// The latency is set by the chain of constant divisions on the time of day
// (reciprocal multiply, remainder, correction, then hours from minutes) and
// by the three-stage day fraction divider that runs alongside.
// The receiver cannot stall, so nothing is held back.
// Reset clears the valid bits of every stage; no item in flight survives it
// and done stays low until a new item has passed through.
// ---------------------------------------------------------------------------
module calendar_date_julian_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [13:0] year,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [15:0] millis_in_minute_in,
	input  logic [8:0]  day_of_year_in,
	input  logic [26:0] millis_of_day_in,
	output logic        done,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [8:0]  day_of_year_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [15:0] millis_in_minute_out,
	output logic [26:0] millis_of_day_out,
	output logic        leap_year,
	output logic [22:0] julian_day_base,
	output logic [31:0] julian_fraction
);

	typedef struct packed {
		cdjc_pkg::op_t op;
		logic [13:0]   year;
		logic          leap;
		logic [3:0]    month;
		logic [4:0]    day;
		logic [8:0]    doy;
		logic [4:0]    hour;
		logic [5:0]    minute;
		logic [15:0]   msm;
		logic [26:0]   msd;
		logic [10:0]   tm;
		logic [16:0]   rem;
		logic [22:0]   jdn;
	} item_t;

	logic  accept;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	item_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	item_t nxt1, nxt2, nxt3, nxt4, nxt5, nxt6;
	logic  frac_valid;
	logic  [31:0] frac_s5;
	logic  [31:0] frac_s6;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: clamps that need no leap flag, and the leap flag itself.
	always_comb begin
		logic [13:0] y25;
		logic        div25;
		y25   = 14'(year * cdjc_pkg::INV25);
		div25 = (y25 <= cdjc_pkg::DIV25_MAX);
		nxt1       = '0;
		nxt1.op    = cdjc_pkg::op_t'(operation);
		nxt1.year  = year;
		nxt1.leap  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
		if (month_in == 4'd0) begin
			nxt1.month = 4'd1;
		end else if (month_in > 4'd12) begin
			nxt1.month = 4'd12;
		end else begin
			nxt1.month = month_in;
		end
		nxt1.day    = day_in;
		nxt1.doy    = day_of_year_in;
		nxt1.hour   = (hour_in > 5'd23) ? 5'd23 : hour_in;
		nxt1.minute = (minute_in > 6'd59) ? 6'd59 : minute_in;
		nxt1.msm    = (millis_in_minute_in > cdjc_pkg::MS_PER_MIN) ?
		              cdjc_pkg::MS_PER_MIN : millis_in_minute_in;
		nxt1.msd    = (millis_of_day_in > cdjc_pkg::MS_MAX_TOD) ?
		              cdjc_pkg::MS_MAX_TOD : millis_of_day_in;
	end

	// Stage 2: date side of a calendar item, or the day of year clamp.
	always_comb begin
		logic [4:0] dim;
		logic [8:0] diy;
		nxt2 = st_s1;
		dim  = cdjc_pkg::month_len(st_s1.month, st_s1.leap);
		diy  = st_s1.leap ? 9'd366 : 9'd365;
		unique case (st_s1.op)
			cdjc_pkg::OP_DATE: begin
				if (st_s1.day == 5'd0) begin
					nxt2.day = 5'd1;
				end else if (st_s1.day > dim) begin
					nxt2.day = dim;
				end
				nxt2.doy = cdjc_pkg::days_before(st_s1.month) + 9'(nxt2.day) +
				           9'((st_s1.leap && st_s1.month > 4'd2) ? 1 : 0);
				nxt2.msd = 27'(27'(st_s1.hour) * 27'(cdjc_pkg::MS_PER_HOUR)) +
				           27'(27'(st_s1.minute) * 27'(cdjc_pkg::MS_PER_MIN)) +
				           27'(st_s1.msm);
			end
			cdjc_pkg::OP_DOY: begin
				if (st_s1.doy == 9'd0) begin
					nxt2.doy = 9'd1;
				end else if (st_s1.doy > diy) begin
					nxt2.doy = diy;
				end
			end
		endcase
	end

	// Stage 3: month and day from day of year; estimate of whole minutes.
	always_comb begin
		logic [3:0]  cnt;
		logic [8:0]  after;
		logic [3:0]  mon;
		logic [43:0] tprod;
		nxt3 = st_s2;
		cnt  = 4'd0;
		for (int i = 1; i <= 11; i++) begin
			after = cdjc_pkg::days_before(4'(i + 1)) +
			        9'((st_s2.leap && i >= 2) ? 1 : 0);
			cnt = cnt + 4'((st_s2.doy > after) ? 1 : 0);
		end
		mon = cnt + 4'd1;
		if (st_s2.op == cdjc_pkg::OP_DOY) begin
			nxt3.month = mon;
			nxt3.day   = 5'(st_s2.doy - cdjc_pkg::days_before(mon) -
			             9'((st_s2.leap && mon > 4'd2) ? 1 : 0));
		end
		tprod   = 44'(st_s2.msd) * 44'(cdjc_pkg::MIN_RECIP);
		nxt3.tm = tprod[42:32];
	end

	// Stage 4: Julian day number; remainder of the minute estimate.
	always_comb begin
		logic        early;
		logic [13:0] yu;
		logic [24:0] yprod;
		logic [23:0] yterm;
		logic [23:0] sum;
		nxt4  = st_s3;
		early = (st_s3.month <= 4'd2);
		yu    = early ? (st_s3.year - 14'd1) : st_s3.year;
		yprod = 25'(yu) * 25'd1461;
		// Year zero in January or February gives y of minus one, truncated to -365.
		if (early && st_s3.year == 14'd0) begin
			yterm = ~24'd364;
		end else begin
			yterm = {1'b0, yprod[24:2]};
		end
		sum = yterm + 24'(cdjc_pkg::month_term(st_s3.month)) + 24'(st_s3.day) +
		      24'(cdjc_pkg::JD_OFFSET);
		nxt4.jdn = sum[22:0];
		nxt4.rem = st_s3.msd[16:0] - 17'(st_s3.tm * 17'(cdjc_pkg::MS_PER_MIN));
	end

	// Stage 5: correct the minute estimate, which is at most one short.
	always_comb begin
		nxt5 = st_s4;
		if (st_s4.rem >= 17'(cdjc_pkg::MS_PER_MIN)) begin
			nxt5.tm  = st_s4.tm + 11'd1;
			nxt5.rem = st_s4.rem - 17'(cdjc_pkg::MS_PER_MIN);
		end
		if (st_s4.op == cdjc_pkg::OP_DOY) begin
			nxt5.msm = nxt5.rem[15:0];
		end
	end

	// Stage 6: hours and minutes from whole minutes of the day.
	always_comb begin
		logic [22:0] hprod;
		logic [4:0]  hr;
		nxt6  = st_s5;
		hprod = 23'(st_s5.tm) * 23'(cdjc_pkg::HOUR_RECIP);
		hr    = hprod[21:17];
		if (st_s5.op == cdjc_pkg::OP_DOY) begin
			nxt6.hour   = hr;
			nxt6.minute = 6'(st_s5.tm - 11'(hr * 11'd60));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		st_s1   <= nxt1;
		st_s2   <= nxt2;
		st_s3   <= nxt3;
		st_s4   <= nxt4;
		st_s5   <= nxt5;
		st_s6   <= nxt6;
		frac_s6 <= frac_s5;
	end

	cdjc_frac_div u_frac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.msd       (st_s2.msd),
		.out_valid (frac_valid),
		.frac      (frac_s5)
	);

	assign done                 = v_s6;
	assign month_out            = st_s6.month;
	assign day_out              = st_s6.day;
	assign day_of_year_out      = st_s6.doy;
	assign hour_out             = st_s6.hour;
	assign minute_out           = st_s6.minute;
	assign millis_in_minute_out = st_s6.msm;
	assign millis_of_day_out    = st_s6.msd;
	assign leap_year            = st_s6.leap;
	assign julian_day_base      = st_s6.jdn;
	assign julian_fraction      = frac_s6;

	// The fraction divider must stay in step with the main pipeline.
	a_frac_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		frac_valid == v_s5)
		else $error("fraction divider out of step with the pipeline");

	// Hours, minutes and milliseconds must recombine to the time of day.
	a_time_split: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (millis_of_day_out ==
		          27'(27'(hour_out) * 27'(cdjc_pkg::MS_PER_HOUR)) +
		          27'(27'(minute_out) * 27'(cdjc_pkg::MS_PER_MIN)) +
		          27'(millis_in_minute_out)))
		else $error("time of day does not match its hour and minute split");

	// Only a full day saturates the fraction.
	a_frac_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((millis_of_day_out == cdjc_pkg::MS_PER_DAY) ==
		          (julian_fraction == 32'hFFFF_FFFF)))
		else $error("day fraction saturation mismatch");

	// A result item always carries a real month and day.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 &&
		          day_out <= cdjc_pkg::month_len(month_out, leap_year)))
		else $error("month or day out of range");

	// Every accepted item is taken as a result once it has passed through every stage.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted item did not produce a result");

endmodule
